// ===== rtl/imhq_pkg.sv =====
// ----------------------------------------------------------------------------
// imhq_pkg
// Types and codes shared by the indexed min-heap queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package imhq_pkg;
  localparam int HANDLE_BITS = 6;
  localparam int NUM_HANDLES = 64;
  localparam int KEY_W = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    CMD_SET = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_POP = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [HANDLE_BITS-1:0] handle;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [HANDLE_BITS-1:0] popped_handle;
    logic [HANDLE_BITS-1:0] min_handle;
    logic signed [KEY_W-1:0] min_key;
    logic [COUNT_W-1:0] count;
    logic empty_res;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD_TAIL,
    S_WR_TAIL,
    S_RD_PARENT,
    S_CMP_UP,
    S_RD_KIDS,
    S_RD_KIDS2,
    S_CMP_DOWN,
    S_SWAP_A,
    S_SWAP_B,
    S_SWAP_B2,
    S_RD_ROOT,
    S_RD_ROOT2,
    S_RESULT
  } state_t;
endpackage

// ===== rtl/imhq_ram.sv =====
// ----------------------------------------------------------------------------
// imhq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/imhq_front.sv =====
// ----------------------------------------------------------------------------
// imhq_front
// Two-entry command queue between the push side and the heap engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module imhq_front
  import imhq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_item_t in_item,
  output logic cmd_valid,
  input  logic cmd_take,
  output in_item_t cmd_item
);
  in_item_t buf_q [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] fill;
  logic do_push, do_take;

  assign full = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd_item = buf_q[rd_ptr];
  assign do_push = push && !full;
  assign do_take = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) buf_q[wr_ptr] <= in_item;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_take) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(do_push) - 2'(do_take);
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("front fill overflow");
  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0) |=> !$past(do_take)) else $error("take from empty");
  a_ptr_fill: assert property (@(posedge clk) disable iff (rst)
    ((fill == 2'd0) || (fill == 2'd2)) |-> (rd_ptr == wr_ptr))
    else $error("pointer mismatch");
endmodule

// ===== rtl/imhq_back.sv =====
// ----------------------------------------------------------------------------
// imhq_back
// Heap engine: slot and position RAMs, sift sequencer, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module imhq_back
  import imhq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_take,
  input  in_item_t cmd_item,
  output logic res_valid,
  input  logic res_take,
  output out_item_t res_item
);
  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = KEY_BITS + HANDLE_BITS;
  localparam int LW = SW + 2;

  state_t state, state_next;
  in_item_t cur;
  logic [CW-1:0] cnt;
  logic [NUM_HANDLES-1:0] present;
  logic [SW-1:0] s, o;
  logic up;
  logic [KEY_BITS-1:0] sk, ok, lk;
  logic [HANDLE_BITS-1:0] sh, oh, lh;
  logic has_r;

  logic we_a;
  logic [SW-1:0] wa_a, ra_a, ra_b;
  logic [EW-1:0] wd_a, rd_a, rd_b;
  logic pwe;
  logic [HANDLE_BITS-1:0] pwa, pra;
  logic [SW-1:0] pwd, prd;

  // two copies of the slot store so two slots can be read at once
  imhq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_slot_a (
    .clk, .we(we_a), .waddr(wa_a), .wdata(wd_a), .raddr(ra_a), .rdata(rd_a));
  imhq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_slot_b (
    .clk, .we(we_a), .waddr(wa_a), .wdata(wd_a), .raddr(ra_b), .rdata(rd_b));
  imhq_ram #(.WIDTH(SW), .DEPTH(NUM_HANDLES)) u_pos (
    .clk, .we(pwe), .waddr(pwa), .wdata(pwd), .raddr(pra), .rdata(prd));

  function automatic logic klt(input logic [KEY_BITS-1:0] a,
                               input logic [KEY_BITS-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  logic [KEY_BITS-1:0] in_key;
  assign in_key = cur.key[KEY_BITS-1:0];
  logic [SW:0] lc_w;
  logic [CW-1:0] s_ext, last_c;
  assign s_ext = CW'(s);
  assign last_c = cnt - CW'(1);
  assign lc_w = {s, 1'b1};

  logic [1:0] status;
  logic [HANDLE_BITS-1:0] popped;

  logic [SW-1:0] s_next, o_next;
  logic up_next, has_r_next, present_clr, present_set;
  logic [KEY_BITS-1:0] sk_next, ok_next, lk_next;
  logic [HANDLE_BITS-1:0] sh_next, oh_next, lh_next;
  logic [CW-1:0] cnt_next;
  logic [1:0] status_next;
  logic [HANDLE_BITS-1:0] popped_next;
  logic res_load;

  assign res_load = (state == S_RESULT) && (!res_valid || res_take);

  always_comb begin
    state_next = state;
    cmd_take = 1'b0;
    we_a = 1'b0; wa_a = s; wd_a = {sk, sh};
    ra_a = s; ra_b = s;
    pwe = 1'b0; pwa = sh; pwd = s; pra = cur.handle;
    s_next = s; o_next = o; up_next = up; has_r_next = has_r;
    sk_next = sk; ok_next = ok; lk_next = lk;
    sh_next = sh; oh_next = oh; lh_next = lh;
    cnt_next = cnt; status_next = status; popped_next = popped;
    present_clr = 1'b0; present_set = 1'b0;
    unique case (state)
      S_IDLE: begin
        pra = cmd_item.handle;
        if (cmd_valid) begin
          cmd_take = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        status_next = ST_OK; popped_next = '0;
        ra_a = '0;
        unique case (cur.cmd)
          CMD_SET: begin
            if (present[cur.handle]) begin
              s_next = prd; sk_next = in_key; sh_next = cur.handle;
              state_next = S_WR_TAIL; up_next = 1'b0;
            end else if (cnt >= CW'(CAPACITY)) begin
              status_next = ST_FULL; state_next = S_RD_ROOT;
            end else begin
              s_next = SW'(cnt); sk_next = in_key; sh_next = cur.handle;
              cnt_next = cnt + CW'(1); present_set = 1'b1;
              up_next = 1'b1; state_next = S_WR_TAIL;
            end
          end
          CMD_REMOVE: begin
            if (!present[cur.handle]) begin
              status_next = ST_ABSENT; state_next = S_RD_ROOT;
            end else begin
              popped_next = cur.handle; present_clr = 1'b1;
              s_next = prd; state_next = S_RD_TAIL;
            end
          end
          CMD_POP: begin
            if (cnt == '0) begin
              status_next = ST_ABSENT; state_next = S_RD_ROOT;
            end else begin
              s_next = '0; state_next = S_RD_TAIL;
            end
          end
          default: state_next = S_RD_ROOT;
        endcase
      end
      S_RD_TAIL: begin
        // rd_b holds slot s, rd_a the tail after this read
        ra_a = SW'(last_c); ra_b = s;
        state_next = S_SWAP_B;
        up_next = 1'b0;
      end
      S_SWAP_B: begin
        if (cur.cmd == CMD_POP) begin
          popped_next = rd_b[HANDLE_BITS-1:0];
          present_clr = 1'b1;
        end
        cnt_next = last_c;
        {sk_next, sh_next} = rd_a;
        if (s_ext == last_c) state_next = S_RD_ROOT;
        else state_next = S_WR_TAIL;
      end
      S_WR_TAIL: begin
        we_a = 1'b1; pwe = 1'b1;
        ra_a = (s == '0) ? s : SW'((s - SW'(1)) >> 1);
        state_next = up ? S_RD_PARENT : S_RD_PARENT;
      end
      S_RD_PARENT: begin
        ra_a = (s == '0) ? s : SW'((s - SW'(1)) >> 1);
        state_next = S_CMP_UP;
      end
      S_CMP_UP: begin
        if (!up && (s == '0 || klt(rd_a[EW-1:HANDLE_BITS], sk))) begin
          state_next = S_RD_KIDS;
        end else if (s != '0 && klt(sk, rd_a[EW-1:HANDLE_BITS])) begin
          up_next = 1'b1;
          o_next = SW'((s - SW'(1)) >> 1);
          {ok_next, oh_next} = rd_a;
          state_next = S_SWAP_A;
        end else begin
          state_next = S_RD_ROOT;
        end
      end
      S_RD_KIDS: begin
        if (LW'(lc_w) >= LW'(cnt)) state_next = S_RD_ROOT;
        else begin
          ra_a = SW'(lc_w); ra_b = SW'(lc_w + 1'b1);
          has_r_next = (LW'(lc_w) + LW'(1)) < LW'(cnt);
          state_next = S_RD_KIDS2;
        end
      end
      S_RD_KIDS2: begin
        ra_a = SW'(lc_w); ra_b = SW'(lc_w + 1'b1);
        if (!has_r || klt(rd_a[EW-1:HANDLE_BITS], rd_b[EW-1:HANDLE_BITS])) begin
          {lk_next, lh_next} = rd_a; o_next = SW'(lc_w);
        end else begin
          {lk_next, lh_next} = rd_b; o_next = SW'(lc_w + 1'b1);
        end
        state_next = S_CMP_DOWN;
      end
      S_CMP_DOWN: begin
        if (klt(lk, sk)) begin
          ok_next = lk; oh_next = lh; state_next = S_SWAP_A;
        end else state_next = S_RD_ROOT;
      end
      S_SWAP_A: begin
        // move other entry into s, current entry into o
        we_a = 1'b1; wa_a = s; wd_a = {ok, oh};
        pwe = 1'b1; pwa = oh; pwd = s;
        s_next = o;
        state_next = S_SWAP_B2;
      end
      S_SWAP_B2: begin
        we_a = 1'b1; wa_a = s; wd_a = {sk, sh};
        pwe = 1'b1; pwa = sh; pwd = s;
        state_next = up ? S_RD_PARENT : S_RD_KIDS;
      end
      S_RD_ROOT: begin
        ra_a = '0;
        state_next = S_RD_ROOT2;
      end
      S_RD_ROOT2: begin
        ra_a = '0;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        // hold the root read while the previous beat is still waiting
        ra_a = '0;
        if (res_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      present <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (present_set) present[cur.handle] <= 1'b1;
      if (present_clr)
        present[(cur.cmd == CMD_POP) ? rd_b[HANDLE_BITS-1:0] : cur.handle] <= 1'b0;
      if (res_load) res_valid <= 1'b1;
      else if (res_take) res_valid <= 1'b0;
    end
    if (cmd_take) cur <= cmd_item;
    s <= s_next; o <= o_next; up <= up_next; has_r <= has_r_next;
    sk <= sk_next; ok <= ok_next; lk <= lk_next;
    sh <= sh_next; oh <= oh_next; lh <= lh_next;
    status <= status_next; popped <= popped_next;
    if (res_load) begin
      res_item.status <= status;
      res_item.popped_handle <= popped;
      res_item.count <= COUNT_W'(cnt);
      res_item.empty_res <= (cnt == '0);
      res_item.min_handle <= (cnt == '0) ? '0 : rd_a[HANDLE_BITS-1:0];
      res_item.min_key <= (cnt == '0) ? '0 : KEY_W'(rd_a[EW-1:HANDLE_BITS]);
    end
  end

  a_cnt_cap: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(CAPACITY))
    else $error("count above capacity");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> (state == S_IDLE)) else $error("take while busy");
  a_res_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT) |=> res_valid) else $error("result lost");
endmodule

// ===== rtl/indexed_min_heap_queue_top.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_top
// Indexed binary min-heap event queue.
// ----------------------------------------------------------------------------
// Input channel: push/full carries one command beat (set_key, remove, pop_min).
// A two-entry front queue accepts beats while the heap engine works.
// Result channel: empty/pop; one result beat per command, in order, showing
// status, removed handle, root handle and key, and element count.
// A rejected or no-op command goes from dispatch to the root read and result.
// Others also read or write the tail, then sift rootward (swap in S_SWAP_A and
// S_SWAP_B2, parent read, compare per level) or leafward (child reads, pick,
// compare, swap in S_SWAP_A and S_SWAP_B2 per level) before the root read.
// Commands are handled one at a time; the next is taken only back in idle.
// Reset clears the count and present flags at once; slot RAMs need no sweep.
// A stalled receiver holds the result beat; the engine finishes the next
// command and waits with it, the front queue fills, then full rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module indexed_min_heap_queue_top
  import imhq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_item_t in_item,
  output logic empty,
  input  logic pop,
  output out_item_t out_item
);
  logic cmd_valid, cmd_take, res_valid;
  in_item_t cmd_item;

  imhq_front u_front (
    .clk, .rst, .push, .full, .in_item,
    .cmd_valid, .cmd_take, .cmd_item);

  imhq_back #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd_item,
    .res_valid, .res_take(pop), .res_item(out_item));

  assign empty = !res_valid;
endmodule
